### sv/stip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_pkg
// Shared types and constants of the string to integer parser.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int unsigned MAX_LENGTH_DEF = 4096;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned COUNT_W        = 13;
    localparam int unsigned MAG_W          = 64;
    localparam int unsigned RADIX_W        = 6;
    localparam int unsigned FLAGS_W        = 3;
    localparam int unsigned UNIT_W         = 16;
    localparam int unsigned ERR_W          = 3;
    localparam int unsigned RES_W          = 1 + MAG_W + COUNT_W + ERR_W;
    localparam int unsigned RES_BYTES_W    = ((RES_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_UNARY = 6'd1;
    localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'h3f;

    localparam logic [UNIT_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [UNIT_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [UNIT_W-1:0] CH_LF    = 16'h000a;
    localparam logic [UNIT_W-1:0] CH_CR    = 16'h000d;
    localparam logic [UNIT_W-1:0] CH_PLUS  = 16'h002b;
    localparam logic [UNIT_W-1:0] CH_MINUS = 16'h002d;
    localparam logic [UNIT_W-1:0] CH_0     = 16'h0030;
    localparam logic [UNIT_W-1:0] CH_9     = 16'h0039;
    localparam logic [UNIT_W-1:0] CH_UA    = 16'h0041;
    localparam logic [UNIT_W-1:0] CH_UB    = 16'h0042;
    localparam logic [UNIT_W-1:0] CH_UX    = 16'h0058;
    localparam logic [UNIT_W-1:0] CH_UZ    = 16'h005a;
    localparam logic [UNIT_W-1:0] CH_LA    = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_LB    = 16'h0062;
    localparam logic [UNIT_W-1:0] CH_LX    = 16'h0078;
    localparam logic [UNIT_W-1:0] CH_LZ    = 16'h007a;

    localparam logic [UNIT_W-1:0] LETTER_OFS = 16'd10;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_BASE   = 3'd1,
        ERR_EMPTY_LEAD = 3'd2,
        ERR_EMPTY_SIGN = 3'd3,
        ERR_EMPTY_PFX  = 3'd4,
        ERR_BAD_CHAR   = 3'd5,
        ERR_JUNK       = 3'd6
    } err_code_t;

    typedef enum logic [7:0] {
        PH_LEAD      = 8'b0000_0001,
        PH_SIGNED    = 8'b0000_0010,
        PH_ZERO_PFX  = 8'b0000_0100,
        PH_AFTER_PFX = 8'b0000_1000,
        PH_ZEROS     = 8'b0001_0000,
        PH_DIGITS    = 8'b0010_0000,
        PH_TRAIL     = 8'b0100_0000,
        PH_HOLD      = 8'b1000_0000
    } phase_t;

    typedef enum logic {
        REG_NUMBER_BASE  = 1'b0,
        REG_OPTION_FLAGS = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic               last;
        logic               none;
        logic               is_space;
        logic               is_zero;
        logic               is_minus;
        logic               is_plus;
        logic               is_x;
        logic               is_b;
        logic [RADIX_W-1:0] digit;
    } cls_t;

endpackage

### sv/stip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_front
// Accepts input words, classifies the code unit and pushes it to the queue.
// ----------------------------------------------------------------------------
module stip_front
    import stip_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [UNIT_W-1:0] s_tdata,   // code_unit
    input  logic              s_tlast,   // end_of_string
    input  logic              s_tuser,   // no_character
    input  logic              q_ready,
    output logic              q_push,
    output cls_t              q_entry
);

    logic [UNIT_W-1:0] c;
    logic [UNIT_W-1:0] dig_wide;

    assign c        = s_tdata;
    assign s_tready = q_ready;
    // an empty word that does not end the string is dropped here
    assign q_push   = s_tvalid && q_ready && !(s_tuser && !s_tlast);

    always_comb begin
        dig_wide = {UNIT_W{1'b1}};
        if (c inside {[CH_0:CH_9]}) begin
            dig_wide = c - CH_0;
        end else if (c inside {[CH_LA:CH_LZ]}) begin
            dig_wide = c - CH_LA + LETTER_OFS;
        end else if (c inside {[CH_UA:CH_UZ]}) begin
            dig_wide = c - CH_UA + LETTER_OFS;
        end
        q_entry.last     = s_tlast;
        q_entry.none     = s_tuser;
        q_entry.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        q_entry.is_zero  = (c == CH_0);
        q_entry.is_minus = (c == CH_MINUS);
        q_entry.is_plus  = (c == CH_PLUS);
        q_entry.is_x     = (c == CH_LX) || (c == CH_UX);
        q_entry.is_b     = (c == CH_LB) || (c == CH_UB);
        q_entry.digit    = (dig_wide == {UNIT_W{1'b1}}) ? DIGIT_NONE : dig_wide[RADIX_W-1:0];
    end

endmodule

### sv/stip_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module stip_queue
    import stip_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cls_t push_entry,
    output logic ready,
    input  logic pop,
    output logic valid,
    output cls_t head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cls_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready)
        else $error("push into full queue");
`endif

endmodule

### sv/stip_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stip_back
// Parse state machine, digit accumulator and result register.
// ----------------------------------------------------------------------------
module stip_back
    import stip_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  cls_t                   q_head,
    output logic                   q_pop,
    input  logic [RADIX_W-1:0]     number_base,
    input  logic [FLAGS_W-1:0]     option_flags,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RES_BYTES_W-1:0] m_tdata
);

    localparam int unsigned POS_W = $clog2(MAX_LENGTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

    phase_t             phase_reg,  phase_next;
    logic               minus_reg,  minus_next;
    logic [RADIX_W-1:0] radix_reg,  radix_next;
    logic [MAG_W-1:0]   acc_reg,    acc_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [POS_W-1:0]   stop_reg,   stop_next;
    err_code_t          pend_reg,   pend_next;

    logic                   out_valid_reg, out_valid_next;
    logic [RES_BYTES_W-1:0] out_data_reg,  out_data_next;

    logic               first;
    logic               base_bad;
    logic [RADIX_W-1:0] radix_start;
    logic [RADIX_W-1:0] radix_eff;
    logic               digit_ok;
    logic [MAG_W-1:0]   mac;
    logic               do_first, do_zeros, do_digit, do_trail;
    logic               res_neg;
    logic [MAG_W-1:0]   res_mag;
    logic [POS_W-1:0]   res_cnt;
    err_code_t          res_err;
    cls_t               e;

    assign e        = q_head;
    assign q_pop    = q_valid && (!e.last || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign first       = (phase_reg == PH_LEAD) && (pos_reg == '0);
    assign base_bad    = (number_base == RADIX_UNARY) || (number_base > RADIX_MAX);
    assign radix_start = first ? number_base : radix_reg;
    assign radix_eff   = (radix_start != '0) ? radix_start :
                         ((phase_reg == PH_ZERO_PFX) ? RADIX_OCT : RADIX_DEC);
    assign digit_ok    = (e.digit < radix_eff);
    assign mac         = acc_reg * {{(MAG_W-RADIX_W){1'b0}}, radix_eff}
                       + {{(MAG_W-RADIX_W){1'b0}}, e.digit};

    always_comb begin
        phase_next = phase_reg;
        minus_next = minus_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        stop_next  = stop_reg;
        pend_next  = pend_reg;
        do_first   = 1'b0;
        do_zeros   = 1'b0;
        do_digit   = 1'b0;
        do_trail   = 1'b0;
        res_neg    = 1'b0;
        res_mag    = '0;
        res_cnt    = '0;
        res_err    = ERR_NONE;

        if (first) begin
            if (base_bad) begin
                pend_next  = ERR_BAD_BASE;
                phase_next = PH_HOLD;
            end else begin
                radix_next = number_base;
            end
        end

        if (!e.none) begin
            case (phase_next)
                PH_LEAD: begin
                    if (option_flags[0] && e.is_space) begin
                        phase_next = PH_LEAD;
                    end else if (e.is_minus) begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGNED;
                    end else if (e.is_plus) begin
                        phase_next = PH_SIGNED;
                    end else begin
                        do_first = 1'b1;
                    end
                end
                PH_SIGNED: begin
                    do_first = 1'b1;
                end
                PH_ZERO_PFX: begin
                    if (e.is_x) begin
                        radix_next = RADIX_HEX;
                        phase_next = PH_AFTER_PFX;
                    end else if (e.is_b) begin
                        radix_next = RADIX_BIN;
                        phase_next = PH_AFTER_PFX;
                    end else begin
                        radix_next = RADIX_OCT;
                        do_zeros   = 1'b1;
                    end
                end
                PH_AFTER_PFX, PH_ZEROS: begin
                    do_zeros = 1'b1;
                end
                PH_DIGITS: begin
                    do_digit = 1'b1;
                end
                PH_TRAIL: begin
                    do_trail = 1'b1;
                end
                default: begin
                    phase_next = phase_next;
                end
            endcase

            if (do_first) begin
                if (radix_next == '0 && e.is_zero) begin
                    phase_next = PH_ZERO_PFX;
                end else begin
                    if (radix_next == '0) begin
                        radix_next = RADIX_DEC;
                    end
                    do_zeros = 1'b1;
                end
            end
            if (do_zeros) begin
                if (e.is_zero) begin
                    phase_next = PH_ZEROS;
                end else begin
                    do_digit = 1'b1;
                end
            end
            if (do_digit) begin
                if (digit_ok) begin
                    acc_next   = mac;
                    phase_next = PH_DIGITS;
                end else if (option_flags[1] || (option_flags[2] && e.is_space)) begin
                    if (option_flags[2]) begin
                        do_trail = 1'b1;
                    end else begin
                        stop_next  = pos_reg;
                        phase_next = PH_HOLD;
                    end
                end else begin
                    pend_next  = ERR_BAD_CHAR;
                    phase_next = PH_HOLD;
                end
            end
            if (do_trail) begin
                if (e.is_space) begin
                    phase_next = PH_TRAIL;
                end else begin
                    pend_next  = ERR_JUNK;
                    phase_next = PH_HOLD;
                end
            end

            if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end

        // end of string: form the result and start over
        if (e.last) begin
            case (phase_next)
                PH_LEAD:      res_err = ERR_EMPTY_LEAD;
                PH_SIGNED:    res_err = ERR_EMPTY_SIGN;
                PH_AFTER_PFX: res_err = ERR_EMPTY_PFX;
                PH_ZERO_PFX, PH_ZEROS: begin
                    res_cnt = pos_next;
                end
                PH_DIGITS, PH_TRAIL: begin
                    res_mag = acc_next;
                    res_cnt = pos_next;
                end
                default: begin
                    if (pend_next != ERR_NONE) begin
                        res_err = pend_next;
                    end else begin
                        res_mag = acc_next;
                        res_cnt = stop_next;
                    end
                end
            endcase
            if (res_err == ERR_NONE) begin
                res_neg = minus_next;
            end else begin
                res_mag = '0;
                res_cnt = '0;
            end
            phase_next = PH_LEAD;
            minus_next = 1'b0;
            radix_next = '0;
            acc_next   = '0;
            pos_next   = '0;
            stop_next  = '0;
            pend_next  = ERR_NONE;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (q_pop && e.last) begin
            out_valid_next = 1'b1;
            out_data_next  = RES_BYTES_W'({res_err, COUNT_W'(res_cnt), res_mag, res_neg});
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_LEAD;
            minus_reg     <= 1'b0;
            radix_reg     <= '0;
            acc_reg       <= '0;
            pos_reg       <= '0;
            stop_reg      <= '0;
            pend_reg      <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg <= phase_next;
                minus_reg <= minus_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                stop_reg  <= stop_next;
                pend_reg  <= pend_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && e.last) |=> (phase_reg == PH_LEAD) && (pos_reg == '0) && (acc_reg == '0))
        else $error("parser not cleared after end of string");
    a_acc_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_reg != '0) |->
            (phase_reg == PH_DIGITS) || (phase_reg == PH_TRAIL) || (phase_reg == PH_HOLD))
        else $error("accumulator set outside digit phases");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && e.last) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_MAX)
        else $error("position above maximum length");
`endif

endmodule

### sv/string_to_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser
// Parses one integer per string of 16-bit code units, one unit per word.
// ----------------------------------------------------------------------------
// path: the end-of-string word is queued, then its result is registered
// throughput: one input word per cycle while the queue has room; the
//   multiply-add of the accumulator in the back end is combinational
// reset: synchronous active-low aresetn clears the parse state, queue and
//   result valid flag; number_base resets to 10 and option_flags to 0
// ----------------------------------------------------------------------------
module string_to_integer_parser
    import stip_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [UNIT_W-1:0]      s_tdata,   // code_unit
    input  logic                   s_tlast,   // end_of_string
    input  logic                   s_tuser,   // no_character
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // negative, magnitude, consumed_count, error_code, zero pad
    output logic [RES_BYTES_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [RADIX_W-1:0] base_reg;
    logic [FLAGS_W-1:0] flags_reg;
    reg_index_t         reg_sel;
    logic               cfg_write;

    logic q_ready, q_push, q_pop, q_valid;
    cls_t q_in, q_head;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (reg_sel)
            REG_NUMBER_BASE:  prdata = {{(32-RADIX_W){1'b0}}, base_reg};
            REG_OPTION_FLAGS: prdata = {{(32-FLAGS_W){1'b0}}, flags_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= RADIX_DEC;
            flags_reg <= '0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_NUMBER_BASE:  base_reg  <= pwdata[RADIX_W-1:0];
                REG_OPTION_FLAGS: flags_reg <= pwdata[FLAGS_W-1:0];
                default:          base_reg  <= base_reg;
            endcase
        end
    end

    stip_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    stip_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .ready      (q_ready),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (q_head)
    );

    stip_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .number_base  (base_reg),
        .option_flags (flags_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

### verif/string_to_integer_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_to_integer_parser_tb
// Streams strings of code units into the parser under several base and option
// settings and varying backpressure. Each parse result is predicted from the
// accepted input words and checked field by field.
// ----------------------------------------------------------------------------
module string_to_integer_parser_tb;
    import stip_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_WORDS    = 30;

    typedef struct packed {
        logic [UNIT_W-1:0] cu;
        logic              last;
        logic              none;
    } text_word_t;

    typedef struct packed {
        logic [RES_BYTES_W-RES_W-1:0] pad;
        err_code_t                    error_code;
        logic [COUNT_W-1:0]           consumed_count;
        logic [MAG_W-1:0]             magnitude;
        logic                         negative;
    } parse_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [UNIT_W-1:0]      s_tdata = '0;   // code_unit
    logic                   s_tlast = 1'b0; // end_of_string
    logic                   s_tuser = 1'b0; // no_character
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // negative, magnitude, consumed_count, error_code, zero pad
    logic [RES_BYTES_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    string_to_integer_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    text_word_t    text_words[$];
    parse_result_t expected_parses[$];
    text_word_t    drive_word;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_done = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    int failures = 0;
    int phase_words = 0;

    // parser copy
    logic [RADIX_W-1:0] base_reg = RADIX_DEC;
    logic [FLAGS_W-1:0] flags_reg = '0;
    phase_t             ph = PH_LEAD;
    logic               minus_seen = 1'b0;
    logic [RADIX_W-1:0] radix = '0;
    logic [MAG_W-1:0]   acc = '0;
    logic [COUNT_W-1:0] pos = '0;
    logic [COUNT_W-1:0] stop_pos = '0;
    err_code_t          pend = ERR_NONE;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic is_ws(logic [UNIT_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [RADIX_W-1:0] unit_digit(logic [UNIT_W-1:0] c);
        logic [UNIT_W-1:0] v;
        v = 16'hffff;
        if (c >= CH_0 && c <= CH_9) v = c - CH_0;
        else if (c >= CH_LA && c <= CH_LZ) v = c - CH_LA + LETTER_OFS;
        else if (c >= CH_UA && c <= CH_UZ) v = c - CH_UA + LETTER_OFS;
        if (v < radix) return v[RADIX_W-1:0];
        return DIGIT_NONE;
    endfunction

    function void trail_unit(logic [UNIT_W-1:0] c);
        if (is_ws(c)) begin
            ph = PH_TRAIL;
        end else begin
            pend = ERR_JUNK;
            ph = PH_HOLD;
        end
    endfunction

    function void digit_unit(logic [UNIT_W-1:0] c, logic [COUNT_W-1:0] idx);
        logic [RADIX_W-1:0] d;
        d = unit_digit(c);
        if (d != DIGIT_NONE) begin
            acc = acc * radix + d;
            ph = PH_DIGITS;
        end else if (flags_reg[1] || (flags_reg[2] && is_ws(c))) begin
            if (flags_reg[2]) begin
                trail_unit(c);
            end else begin
                stop_pos = idx;
                ph = PH_HOLD;
            end
        end else begin
            pend = ERR_BAD_CHAR;
            ph = PH_HOLD;
        end
    endfunction

    function void zeros_unit(logic [UNIT_W-1:0] c, logic [COUNT_W-1:0] idx);
        if (c == CH_0) ph = PH_ZEROS;
        else digit_unit(c, idx);
    endfunction

    function void first_unit(logic [UNIT_W-1:0] c, logic [COUNT_W-1:0] idx);
        if (radix == 0) begin
            if (c == CH_0) begin
                ph = PH_ZERO_PFX;
                return;
            end
            radix = RADIX_DEC;
        end
        zeros_unit(c, idx);
    endfunction

    function void take_unit(logic [UNIT_W-1:0] c, logic [COUNT_W-1:0] idx);
        case (ph)
            PH_LEAD: begin
                if (!(flags_reg[0] && is_ws(c))) begin
                    if (c == CH_MINUS) begin
                        minus_seen = 1'b1;
                        ph = PH_SIGNED;
                    end else if (c == CH_PLUS) begin
                        ph = PH_SIGNED;
                    end else begin
                        first_unit(c, idx);
                    end
                end
            end
            PH_SIGNED: first_unit(c, idx);
            PH_ZERO_PFX: begin
                if (c == CH_LX || c == CH_UX) begin
                    radix = RADIX_HEX;
                    ph = PH_AFTER_PFX;
                end else if (c == CH_LB || c == CH_UB) begin
                    radix = RADIX_BIN;
                    ph = PH_AFTER_PFX;
                end else begin
                    radix = RADIX_OCT;
                    zeros_unit(c, idx);
                end
            end
            PH_AFTER_PFX, PH_ZEROS: zeros_unit(c, idx);
            PH_DIGITS: digit_unit(c, idx);
            PH_TRAIL: trail_unit(c);
            default: ;
        endcase
    endfunction

    function void parse_code_unit(logic [UNIT_W-1:0] c, logic last, logic none);
        parse_result_t r;
        err_code_t     e;
        logic [MAG_W-1:0]   mag;
        logic [COUNT_W-1:0] cnt;
        if (none && !last) return;
        if (ph == PH_LEAD && pos == 0) begin
            if (base_reg == RADIX_UNARY || base_reg > RADIX_MAX) begin
                pend = ERR_BAD_BASE;
                ph = PH_HOLD;
            end else begin
                radix = base_reg;
            end
        end
        if (!none) begin
            take_unit(c, pos);
            if (pos < MAX_LENGTH_DEF) pos = pos + 1'b1;
        end
        if (!last) return;
        e = ERR_NONE;
        mag = '0;
        cnt = '0;
        case (ph)
            PH_LEAD: e = ERR_EMPTY_LEAD;
            PH_SIGNED: e = ERR_EMPTY_SIGN;
            PH_AFTER_PFX: e = ERR_EMPTY_PFX;
            PH_ZERO_PFX, PH_ZEROS: cnt = pos;
            PH_DIGITS, PH_TRAIL: begin
                mag = acc;
                cnt = pos;
            end
            default: begin
                if (pend != ERR_NONE) begin
                    e = pend;
                end else begin
                    mag = acc;
                    cnt = stop_pos;
                end
            end
        endcase
        r = '0;
        r.error_code = e;
        if (e == ERR_NONE) begin
            r.negative = minus_seen;
            r.magnitude = mag;
            r.consumed_count = cnt;
        end
        expected_parses.push_back(r);
        ph = PH_LEAD;
        minus_seen = 1'b0;
        radix = '0;
        acc = '0;
        pos = '0;
        stop_pos = '0;
        pend = ERR_NONE;
    endfunction

    function void check_result(parse_result_t got);
        parse_result_t want;
        if (expected_parses.size() == 0) begin
            $error("result word with no parse pending: %h", got);
            failures++;
            return;
        end
        want = expected_parses.pop_front();
        if (got.negative !== want.negative) begin
            $error("negative: expected %0d, got %0d", want.negative, got.negative);
            failures++;
        end
        if (got.magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
            failures++;
        end
        if (got.consumed_count !== want.consumed_count) begin
            $error("consumed_count: expected %0d, got %0d",
                   want.consumed_count, got.consumed_count);
            failures++;
        end
        if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            failures++;
        end
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (text_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_word = text_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= drive_word.cu;
                s_tlast <= drive_word.last;
                s_tuser <= drive_word.none;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) parse_code_unit(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready) check_result(parse_result_t'(m_tdata));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("string_to_integer_parser_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic push_word(logic [UNIT_W-1:0] cu, logic last, logic none);
        text_word_t w;
        w.cu = cu;
        w.last = last;
        w.none = none;
        text_words.push_back(w);
        if (!none || last) phase_words++;
    endtask

    task automatic add_text(string txt, bit none_end);
        for (int i = 0; i < txt.len(); i++)
            push_word({8'h00, txt[i]}, (i == txt.len() - 1) && !none_end, 1'b0);
        if (none_end || txt.len() == 0) push_word(16'($urandom), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (text_words.size() != 0 || s_tvalid || expected_parses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(reg_index_t idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_NUMBER_BASE) base_reg = value[RADIX_W-1:0];
        else flags_reg = value[FLAGS_W-1:0];
    endtask

    task automatic apply_config(logic [RADIX_W-1:0] base, logic [FLAGS_W-1:0] flags);
        wait_drained();
        reg_write(REG_NUMBER_BASE, 32'(base));
        reg_write(REG_OPTION_FLAGS, 32'(flags));
    endtask

    function automatic logic [UNIT_W-1:0] ws_unit();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [UNIT_W-1:0] noise_unit();
        if ($urandom_range(0, 1)) return 16'($urandom);
        return 16'($urandom_range(0, 127));
    endfunction

    task automatic add_random_string();
        logic [UNIT_W-1:0] txt[$];
        logic [RADIX_W-1:0] rdx;
        int n;
        int v;
        bit none_end;
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 5);
            repeat (n) txt.push_back(noise_unit());
        end else begin
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3)) txt.push_back(ws_unit());
            if ($urandom_range(0, 99) < 40)
                txt.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (base_reg == 0) begin
                v = $urandom_range(0, 9);
                if (v < 3) begin
                    txt.push_back(CH_0);
                    txt.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                    rdx = RADIX_HEX;
                end else if (v < 5) begin
                    txt.push_back(CH_0);
                    txt.push_back($urandom_range(0, 1) ? CH_LB : CH_UB);
                    rdx = RADIX_BIN;
                end else if (v < 7) begin
                    txt.push_back(CH_0);
                    rdx = RADIX_OCT;
                end else begin
                    rdx = RADIX_DEC;
                end
            end else if (base_reg == RADIX_UNARY || base_reg > RADIX_MAX) begin
                rdx = RADIX_DEC;
            end else begin
                rdx = base_reg;
            end
            if ($urandom_range(0, 99) < 25)
                repeat ($urandom_range(1, 3)) txt.push_back(CH_0);
            if ($urandom_range(0, 99) < 92) begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                repeat (n) begin
                    v = $urandom_range(0, rdx - 1);
                    if (v < 10) txt.push_back(CH_0 + 16'(v));
                    else txt.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 16'(v - 10));
                end
            end
            v = $urandom_range(0, 99);
            if (v < 20) repeat ($urandom_range(1, 2)) txt.push_back(ws_unit());
            else if (v < 35) txt.push_back(noise_unit());
            if (txt.size() > 0 && $urandom_range(0, 99) < 10)
                txt[$urandom_range(0, txt.size() - 1)] = noise_unit();
        end
        none_end = ($urandom_range(0, 99) < 15) || txt.size() == 0;
        foreach (txt[i]) begin
            // ignored empty word
            if ($urandom_range(0, 99) < 5) push_word(16'($urandom), 1'b0, 1'b1);
            push_word(txt[i], (i == txt.size() - 1) && !none_end, 1'b0);
        end
        if (none_end) push_word(16'($urandom), 1'b1, 1'b1);
    endtask

    initial begin
        logic [RADIX_W-1:0] bases[16];
        bases = '{6'd10, 6'd0, 6'd2, 6'd16, 6'd36, 6'd8, 6'd0, 6'd1,
                  6'd63, 6'd3, 6'd0, 6'd37, 6'd10, 6'd0, 6'd16, 6'd0};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: base 10, no options
        add_text("-000", 0);
        add_text("", 1);
        add_text("+", 0);
        add_text("7x", 0);
        push_word(16'hffff, 1'b0, 1'b1);
        add_text("9", 1);

        apply_config(6'd0, 3'd1);
        add_text(" 0x1F", 0);
        add_text("0", 0);
        add_text("0b", 0);
        add_text("017", 0);
        add_text("\t", 0);

        apply_config(6'd36, 3'd2);
        push_word("z", 1'b0, 1'b0);
        push_word(16'hffff, 1'b0, 1'b0);
        push_word(16'h0000, 1'b1, 1'b0);

        apply_config(6'd16, 3'd6);
        add_text("ff \n", 0);
        add_text("f x", 0);
        add_text("+Ab", 1);

        apply_config(6'd1, 3'd0);
        add_text("1", 0);
        apply_config(6'd63, 3'd0);
        add_text("5", 0);

        for (int i = 0; i < 16; i++) begin
            apply_config(bases[i], 3'(i % 8));
            case (i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            phase_words = 0;
            if (i == 6) begin
                hold_requests++;
                for (int k = 0; k < 12; k++) add_text($sformatf("%0d", k % 10), 0);
            end
            while (phase_words < PHASE_WORDS) add_random_string();
        end

        wait_drained();
        if (failures == 0) begin
            $display("string_to_integer_parser_tb OK");
        end else begin
            $display("string_to_integer_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
